// ===== rtl/zmh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zmh_pkg
// Shared types, piece codes and helpers of the move hash update core.
// ----------------------------------------------------------------------------
package zmh_pkg;

   // Board and key store geometry.
   localparam int BOARD_SQUARES = 64;
   localparam int SQ_W          = $clog2(BOARD_SQUARES);
   localparam int PIECE_KINDS   = 12;
   localparam int PIECE_W       = 4;
   localparam int KEY_DEPTH     = PIECE_KINDS * BOARD_SQUARES;
   localparam int KEY_ADDR_W    = $clog2(KEY_DEPTH);
   localparam int KEY_W         = 64;
   localparam int FILES         = 8;
   localparam int FILE_W        = $clog2(FILES);

   // Piece codes.
   localparam logic [PIECE_W-1:0] WHITE_PAWN  = 4'd0;
   localparam logic [PIECE_W-1:0] WHITE_ROOK  = 4'd3;
   localparam logic [PIECE_W-1:0] WHITE_KING  = 4'd5;
   localparam logic [PIECE_W-1:0] BLACK_PAWN  = 4'd6;
   localparam logic [PIECE_W-1:0] BLACK_ROOK  = 4'd9;
   localparam logic [PIECE_W-1:0] SIDE_SELECT = 4'd12;

   // Castling target files, counted from zero.
   localparam logic [FILE_W-1:0] QUEEN_SIDE_FILE = 3'd2;
   localparam logic [FILE_W-1:0] KING_SIDE_FILE  = 3'd6;

   // Key reads of one move, in issue order.
   localparam int NUM_SLOTS   = 5;
   localparam int SLOT_W      = $clog2(NUM_SLOTS);
   localparam int SLOT_SRC    = 0;
   localparam int SLOT_TAKEN  = 1;
   localparam int SLOT_ROOK_A = 2;
   localparam int SLOT_ROOK_B = 3;
   localparam int SLOT_DST    = 4;

   // Result queue.
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = RSP_PTR_W + 1;

   typedef enum logic [2:0] {
      MODE_LOAD   = 3'd0,
      MODE_CLEAR  = 3'd1,
      MODE_TOGGLE = 3'd2,
      MODE_SIDE   = 3'd3,
      MODE_MOVE   = 3'd4
   } mode_type;

   // Codes above eleven act as the white pawn.
   function automatic logic [PIECE_W-1:0] norm_piece(input logic [PIECE_W-1:0] code);
      norm_piece = (code < PIECE_W'(PIECE_KINDS)) ? code : WHITE_PAWN;
   endfunction

   // Key store address of a piece on a square.
   function automatic logic [KEY_ADDR_W-1:0] key_addr(input logic [PIECE_W-1:0] piece,
                                                     input logic [SQ_W-1:0] square);
      key_addr = {piece, square};
   endfunction

endpackage
`default_nettype wire

// ===== rtl/zobrist_move_hash_update_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zobrist_move_hash_update_core
// Incremental chess position hash with a loadable key store.
// ----------------------------------------------------------------------------
// Every request beat returns one response beat with the hash after it. Load,
// clear, side toggle and unused modes read no key word; a piece toggle reads
// one; a move reads one key word at a time for each one it needs
// (source, capture or en passant victim, two rook squares, target), because
// the key store has a single read port. A new request is taken in the cycle
// the previous one issues its last read, if the response queue has room, and
// results reach the response port through a four-beat response queue.
// The key store holds no reset value and must be loaded before it is used.

module zobrist_move_hash_update_core
   import zmh_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [3:0] moving_piece, [9:4] from_square, [15:10] to_square,
   // [19:16] captured_piece, [23:20] promoted_piece, [24] is_en_passant,
   // [25] is_capture, [26] is_castling, [27] is_promotion, [91:28] key_word,
   // [95:92] zero
   input  wire logic [95:0] req_tdata,
   // [2:0] mode
   input  wire logic [2:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [63:0] position_hash
   output logic [63:0]      rsp_tdata
);

   // Request fields.
   logic [PIECE_W-1:0] f_moving;
   logic [SQ_W-1:0]    f_from;
   logic [SQ_W-1:0]    f_to;
   logic [PIECE_W-1:0] f_captured;
   logic [PIECE_W-1:0] f_promoted;
   logic               f_ep;
   logic               f_capture;
   logic               f_castle;
   logic               f_promo;
   logic [KEY_W-1:0]   f_key;
   mode_type           f_mode;

   assign f_moving   = req_tdata[3:0];
   assign f_from     = req_tdata[9:4];
   assign f_to       = req_tdata[15:10];
   assign f_captured = req_tdata[19:16];
   assign f_promoted = req_tdata[23:20];
   assign f_ep       = req_tdata[24];
   assign f_capture  = req_tdata[25];
   assign f_castle   = req_tdata[26];
   assign f_promo    = req_tdata[27];
   assign f_key      = req_tdata[91:28];
   assign f_mode     = mode_type'(req_tuser);

   // Issue stage registers.
   logic                  a_valid_ff, a_valid_in;
   logic [NUM_SLOTS-1:0]  a_mask_ff, a_mask_in;
   logic [KEY_ADDR_W-1:0] a_addr_ff [NUM_SLOTS];
   logic [KEY_ADDR_W-1:0] a_addr_in [NUM_SLOTS];
   mode_type              a_mode_ff;
   logic [PIECE_W-1:0]    a_code_ff;
   logic [SQ_W-1:0]       a_from_ff;
   logic [KEY_W-1:0]      a_key_ff;

   // Accumulate stage registers.
   logic             b_mem_ff, b_final_ff, b_clear_ff, b_side_ff;
   logic [KEY_W-1:0] mem_q_ff;
   logic [KEY_W-1:0] hash_ff, hash_in;
   logic [KEY_W-1:0] side_key_ff;

   // Key store.
   logic [KEY_W-1:0] key_mem [KEY_DEPTH];

   // Response queue.
   logic [KEY_W-1:0]     rsp_buf_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] rsp_wr_ff, rsp_rd_ff;
   logic [RSP_CNT_W-1:0] rsp_cnt_ff;

   logic                  req_beat, rsp_beat;
   logic                  can_final, a_single, a_step, a_done, rd_en;
   logic [SLOT_W-1:0]     sel;
   logic [KEY_ADDR_W-1:0] rd_addr;
   logic [PIECE_W-1:0]    mover;
   logic [PIECE_W-1:0]    victim;
   logic [PIECE_W-1:0]    rook;
   logic [SQ_W-1:0]       ep_sq;
   logic [SQ_W-1:0]       rank_base;
   logic                  castle_q, castle_k;

   // Handshake and issue control. A request may finish only if the queue
   // still has room once the beat already on its way has been written.
   assign req_beat  = req_tvalid && req_tready;
   assign rsp_beat  = rsp_tvalid && rsp_tready;
   assign can_final = ({1'b0, rsp_cnt_ff} + {{RSP_CNT_W{1'b0}}, b_final_ff})
                      < (RSP_CNT_W + 1)'(RSP_DEPTH);
   assign a_single  = (a_mask_ff & (a_mask_ff - NUM_SLOTS'(1))) == '0;
   assign a_step    = a_valid_ff && (!a_single || can_final);
   assign a_done    = a_valid_ff && a_single && can_final;
   assign rd_en     = a_step && (a_mask_ff != '0);
   assign req_tready = !a_valid_ff || a_done;

   // Lowest pending read slot.
   always_comb begin
      sel = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (a_mask_ff[i]) begin
            sel = SLOT_W'(i);
         end
      end
   end

   assign rd_addr = a_addr_ff[sel];

   // Read list of an incoming request.
   assign mover     = norm_piece(f_moving);
   assign victim    = (mover == WHITE_PAWN) ? BLACK_PAWN : WHITE_PAWN;
   assign rook      = (mover == WHITE_KING) ? WHITE_ROOK : BLACK_ROOK;
   assign ep_sq     = (mover < BLACK_PAWN) ? f_to - SQ_W'(FILES) : f_to + SQ_W'(FILES);
   assign rank_base = {f_to[SQ_W-1:FILE_W], {FILE_W{1'b0}}};
   assign castle_q  = f_castle && (f_to[FILE_W-1:0] == QUEEN_SIDE_FILE);
   assign castle_k  = f_castle && (f_to[FILE_W-1:0] == KING_SIDE_FILE);

   always_comb begin
      a_mask_in = '0;
      a_addr_in[SLOT_SRC]    = key_addr(mover, f_from);
      a_addr_in[SLOT_TAKEN]  = f_ep ? key_addr(victim, ep_sq)
                                    : key_addr(norm_piece(f_captured), f_to);
      a_addr_in[SLOT_ROOK_A] = castle_q ? key_addr(rook, rank_base)
                                        : key_addr(rook, rank_base + SQ_W'(7));
      a_addr_in[SLOT_ROOK_B] = castle_q ? key_addr(rook, rank_base + SQ_W'(3))
                                        : key_addr(rook, rank_base + SQ_W'(5));
      a_addr_in[SLOT_DST]    = key_addr(f_promo ? norm_piece(f_promoted) : mover, f_to);
      case (f_mode)
         MODE_TOGGLE: begin
            a_mask_in[SLOT_SRC] = 1'b1;
         end
         MODE_MOVE: begin
            a_mask_in[SLOT_SRC]    = 1'b1;
            a_mask_in[SLOT_TAKEN]  = f_ep || f_capture;
            a_mask_in[SLOT_ROOK_A] = castle_q || castle_k;
            a_mask_in[SLOT_ROOK_B] = castle_q || castle_k;
            a_mask_in[SLOT_DST]    = 1'b1;
         end
         default: begin
            a_mask_in = '0;
         end
      endcase
   end

   always_comb begin
      a_valid_in = a_valid_ff;
      if (req_beat) begin
         a_valid_in = 1'b1;
      end else if (a_done) begin
         a_valid_in = 1'b0;
      end
   end

   // Issue stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
      if (req_beat) begin
         a_mask_ff <= a_mask_in;
         a_addr_ff <= a_addr_in;
         a_mode_ff <= f_mode;
         a_code_ff <= f_moving;
         a_from_ff <= f_from;
         a_key_ff  <= f_key;
      end else if (a_step) begin
         a_mask_ff <= a_mask_ff & (a_mask_ff - NUM_SLOTS'(1));
      end
   end

   // Key store: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (a_done && a_mode_ff == MODE_LOAD && a_code_ff < PIECE_W'(PIECE_KINDS)) begin
         key_mem[key_addr(a_code_ff, a_from_ff)] <= a_key_ff;
      end
      if (rd_en) begin
         mem_q_ff <= key_mem[rd_addr];
      end
   end

   // Side key register and accumulate stage control.
   always_ff @(posedge clock) begin
      if (reset) begin
         side_key_ff <= '0;
         b_mem_ff    <= 1'b0;
         b_final_ff  <= 1'b0;
         b_clear_ff  <= 1'b0;
         b_side_ff   <= 1'b0;
      end else begin
         if (a_done && a_mode_ff == MODE_LOAD && a_code_ff == SIDE_SELECT) begin
            side_key_ff <= a_key_ff;
         end
         b_mem_ff   <= rd_en;
         b_final_ff <= a_done;
         b_clear_ff <= a_done && (a_mode_ff == MODE_CLEAR);
         b_side_ff  <= a_done && (a_mode_ff == MODE_SIDE || a_mode_ff == MODE_MOVE);
      end
   end

   // Fold the returned key word, then apply the closing operation.
   always_comb begin
      hash_in = hash_ff ^ (b_mem_ff ? mem_q_ff : '0);
      if (b_clear_ff) begin
         hash_in = '0;
      end else if (b_side_ff) begin
         hash_in = hash_in ^ side_key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= '0;
      end else begin
         hash_ff <= hash_in;
      end
   end

   // Response queue.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_wr_ff  <= '0;
         rsp_rd_ff  <= '0;
         rsp_cnt_ff <= '0;
      end else begin
         if (b_final_ff) begin
            rsp_wr_ff <= rsp_wr_ff + RSP_PTR_W'(1);
         end
         if (rsp_beat) begin
            rsp_rd_ff <= rsp_rd_ff + RSP_PTR_W'(1);
         end
         rsp_cnt_ff <= rsp_cnt_ff + RSP_CNT_W'(b_final_ff) - RSP_CNT_W'(rsp_beat);
      end
      if (b_final_ff) begin
         rsp_buf_ff[rsp_wr_ff] <= hash_in;
      end
   end

   assign rsp_tvalid = (rsp_cnt_ff != '0);
   assign rsp_tdata  = rsp_buf_ff[rsp_rd_ff];

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Zobrist move hash update core.
// After reset the bench fills the whole key store and then walks a short
// table of directed beats: unused modes, loads with codes that write nothing,
// the side key, every move special case, and a move applied twice so that it
// undoes itself. A long random run follows. Each response beat is compared
// against a bench-side model of the hash and key store. Both channels stall
// at random.
// ----------------------------------------------------------------------------

module testbench;
   import zmh_pkg::*;

   // Mode codes with no operation behind them.
   localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
   localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

   // Piece codes used in the directed table, on top of the package ones.
   localparam logic [3:0] WHITE_KNIGHT = 4'd1;
   localparam logic [3:0] WHITE_BISHOP = 4'd2;
   localparam logic [3:0] WHITE_QUEEN  = 4'd4;
   localparam logic [3:0] BLACK_KNIGHT = 4'd7;
   localparam logic [3:0] BLACK_QUEEN  = 4'd10;
   localparam logic [3:0] BLACK_KING   = 4'd11;
   localparam logic [3:0] NO_PIECE_A   = 4'd13;
   localparam logic [3:0] NO_PIECE_C   = 4'd15;

   // Rook files of a castling move, counted from zero.
   localparam logic [2:0] QUEEN_ROOK_HOME = 3'd0;
   localparam logic [2:0] QUEEN_ROOK_DEST = 3'd3;
   localparam logic [2:0] KING_ROOK_HOME  = 3'd7;
   localparam logic [2:0] KING_ROOK_DEST  = 3'd5;

   // Move flag bits of a table row, {promotion, castling, capture, en passant}.
   localparam logic [3:0] F_NONE   = 4'b0000;
   localparam logic [3:0] F_EP     = 4'b0001;
   localparam logic [3:0] F_CAP    = 4'b0010;
   localparam logic [3:0] F_CASTLE = 4'b0100;
   localparam logic [3:0] F_PROMO  = 4'b1000;

   localparam logic [63:0] ALL_ONES = '1;

   // Request payload in the order of req_tdata, highest field first.
   typedef struct packed {
      logic [3:0]  pad;
      logic [63:0] key_word;
      logic        is_promotion;
      logic        is_castling;
      logic        is_capture;
      logic        is_en_passant;
      logic [3:0]  promoted_piece;
      logic [3:0]  captured_piece;
      logic [5:0]  to_square;
      logic [5:0]  from_square;
      logic [3:0]  moving_piece;
   } hash_req_type;

   typedef struct {
      logic [2:0]   mode;
      hash_req_type req;
      bit           fixed;
      logic [63:0]  hash;
   } directed_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata  = '0;
   logic [2:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;

   // Bench copy of the key store, the side key and the running hash.
   logic [63:0] key_model [0:KEY_DEPTH-1];
   logic [63:0] side_model = '0;
   logic [63:0] hash_model = '0;

   logic [63:0] pending_hashes [$];
   int          mismatch_count = 0;
   int          cycle_count    = 0;
   bit          sender_calm    = 1'b0;

   always #5 clock = ~clock;

   zobrist_move_hash_update_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Codes above the last piece stand for the white pawn.
   function automatic logic [3:0] board_piece(logic [3:0] code);
      return (code < PIECE_KINDS) ? code : WHITE_PAWN;
   endfunction

   function automatic logic [63:0] key_of(logic [3:0] piece, logic [5:0] square);
      return key_model[{piece, square}];
   endfunction

   // Updates the bench state for one request beat and returns the new hash.
   function automatic logic [63:0] next_position_hash(logic [2:0] m, hash_req_type r);
      logic [3:0]  mover;
      logic [3:0]  rook;
      logic [5:0]  dst;
      logic [5:0]  victim_sq;
      logic [63:0] h;
      mover = board_piece(r.moving_piece);
      dst   = r.to_square;
      h     = hash_model;
      case (m)
         MODE_LOAD: begin
            if (r.moving_piece < PIECE_KINDS)
               key_model[{r.moving_piece, r.from_square}] = r.key_word;
            else if (r.moving_piece == SIDE_SELECT)
               side_model = r.key_word;
         end
         MODE_CLEAR:  h = '0;
         MODE_TOGGLE: h ^= key_of(mover, r.from_square);
         MODE_SIDE:   h ^= side_model;
         MODE_MOVE: begin
            h ^= key_of(mover, r.from_square);
            // En passant wins over a plain capture; the victim square wraps.
            if (r.is_en_passant) begin
               victim_sq = (mover < BLACK_PAWN) ? dst - 6'(FILES) : dst + 6'(FILES);
               h ^= key_of((mover == WHITE_PAWN) ? BLACK_PAWN : WHITE_PAWN, victim_sq);
            end else if (r.is_capture) begin
               h ^= key_of(board_piece(r.captured_piece), dst);
            end
            // Only the two castling files move a rook.
            if (r.is_castling) begin
               rook = (mover == WHITE_KING) ? WHITE_ROOK : BLACK_ROOK;
               if (dst[2:0] == QUEEN_SIDE_FILE) begin
                  h ^= key_of(rook, {dst[5:3], QUEEN_ROOK_HOME});
                  h ^= key_of(rook, {dst[5:3], QUEEN_ROOK_DEST});
               end else if (dst[2:0] == KING_SIDE_FILE) begin
                  h ^= key_of(rook, {dst[5:3], KING_ROOK_HOME});
                  h ^= key_of(rook, {dst[5:3], KING_ROOK_DEST});
               end
            end
            h ^= key_of(r.is_promotion ? board_piece(r.promoted_piece) : mover, dst);
            h ^= side_model;
         end
         default: ;
      endcase
      hash_model = h;
      return h;
   endfunction

   function automatic directed_row_type table_row(logic [2:0] m, logic [3:0] piece,
                                                  logic [5:0] from_sq, logic [5:0] to_sq,
                                                  logic [3:0] taken, logic [3:0] promo,
                                                  logic [3:0] flags, logic [63:0] key,
                                                  bit fixed, logic [63:0] hash);
      directed_row_type row;
      row.mode                = m;
      row.req                 = '0;
      row.req.moving_piece    = piece;
      row.req.from_square     = from_sq;
      row.req.to_square       = to_sq;
      row.req.captured_piece  = taken;
      row.req.promoted_piece  = promo;
      row.req.is_en_passant   = flags[0];
      row.req.is_capture      = flags[1];
      row.req.is_castling     = flags[2];
      row.req.is_promotion    = flags[3];
      row.req.key_word        = key;
      row.fixed               = fixed;
      row.hash                = hash;
      return row;
   endfunction

   // Drives one request beat, records its expected hash once accepted, and
   // then idles at random unless the sender is in its calm stretch.
   task automatic send_item(input logic [2:0] m, input hash_req_type r,
                            input bit use_fixed, input logic [63:0] fixed_hash);
      logic [63:0] predicted;
      req_tvalid <= 1'b1;
      req_tuser  <= m;
      req_tdata  <= r;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = next_position_hash(m, r);
      pending_hashes.push_back(use_fixed ? fixed_hash : predicted);
      if (!sender_calm && $urandom_range(99) < 26) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < 26) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_hashes.size() != 0) @(posedge clock);
   endtask

   // Response side: check each accepted beat and stall at random, except
   // for one long stretch with the ready held high.
   always @(posedge clock) begin : response_check
      logic [63:0] want;
      cycle_count++;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_hashes.size() == 0) begin
            $display("%0t: response beat %h with no hash expected", $time, rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_hashes.pop_front();
            if (rsp_tdata !== want) begin
               $display("%0t: position_hash expected %h actual %h", $time, want, rsp_tdata);
               mismatch_count++;
            end
         end
      end
      rsp_tready <= reset ? 1'b0 :
                    ((cycle_count >= 1200 && cycle_count < 2400) || $urandom_range(99) >= 26);
   end

   initial begin : stimulus
      directed_row_type rows [$];
      hash_req_type     r;
      hash_req_type     last_move;
      logic [2:0]       m;
      int               pick;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill every piece key so that no read ever hits an unwritten entry.
      // The side key stays at its reset value of zero.
      for (int p = 0; p < PIECE_KINDS; p++) begin
         for (int s = 0; s < BOARD_SQUARES; s++) begin
            r              = '0;
            r.moving_piece = 4'(p);
            r.from_square  = 6'(s);
            r.key_word     = {$urandom, $urandom};
            send_item(MODE_LOAD, r, 1'b0, '0);
         end
      end

      // Directed table. Rows marked fixed carry a hash that is plain to see.
      rows.push_back(table_row(MODE_SIDE, 0, 0, 0, 0, 0, F_NONE, '0, 1, '0));
      rows.push_back(table_row(MODE_UNUSED_LO, 0, 0, 0, 0, 0, F_NONE, ALL_ONES, 1, '0));
      rows.push_back(table_row(MODE_UNUSED_HI, NO_PIECE_C, 63, 63, 15, 15, 4'hF, ALL_ONES,
                               1, '0));
      rows.push_back(table_row(MODE_LOAD, NO_PIECE_A, 63, 0, 0, 0, F_NONE, ALL_ONES, 1, '0));
      rows.push_back(table_row(MODE_LOAD, NO_PIECE_C, 21, 0, 0, 0, F_NONE, ALL_ONES, 1, '0));
      rows.push_back(table_row(MODE_SIDE, 0, 0, 0, 0, 0, F_NONE, '0, 1, '0));
      rows.push_back(table_row(MODE_LOAD, SIDE_SELECT, 0, 0, 0, 0, F_NONE, ALL_ONES, 1, '0));
      rows.push_back(table_row(MODE_SIDE, 0, 0, 0, 0, 0, F_NONE, '0, 1, ALL_ONES));
      rows.push_back(table_row(MODE_CLEAR, 0, 0, 0, 0, 0, F_NONE, '0, 1, '0));
      rows.push_back(table_row(MODE_LOAD, WHITE_PAWN, 0, 0, 0, 0, F_NONE, ALL_ONES, 1, '0));
      rows.push_back(table_row(MODE_TOGGLE, WHITE_PAWN, 0, 0, 0, 0, F_NONE, '0, 1, ALL_ONES));
      rows.push_back(table_row(MODE_LOAD, BLACK_KING, 63, 0, 0, 0, F_NONE, '0, 1, ALL_ONES));
      rows.push_back(table_row(MODE_TOGGLE, BLACK_KING, 63, 0, 0, 0, F_NONE, '0, 1, ALL_ONES));
      rows.push_back(table_row(MODE_TOGGLE, NO_PIECE_C, 63, 0, 0, 0, F_NONE, '0, 0, '0));
      // Moves: plain, captures, en passant with wrap, castling, promotion.
      rows.push_back(table_row(MODE_MOVE, WHITE_KNIGHT, 6, 21, 0, 0, F_NONE, '0, 0, '0));
      rows.push_back(table_row(MODE_MOVE, WHITE_BISHOP, 2, 38, BLACK_KNIGHT, 0, F_CAP, '0,
                               0, '0));
      rows.push_back(table_row(MODE_MOVE, BLACK_QUEEN, 59, 27, NO_PIECE_A, 0, F_CAP, '0,
                               0, '0));
      rows.push_back(table_row(MODE_MOVE, WHITE_PAWN, 11, 3, BLACK_ROOK, 0, F_EP | F_CAP, '0,
                               0, '0));
      rows.push_back(table_row(MODE_MOVE, BLACK_PAWN, 52, 60, 0, 0, F_EP, '0, 0, '0));
      rows.push_back(table_row(MODE_MOVE, WHITE_KNIGHT, 30, 45, 0, 0, F_EP, '0, 0, '0));
      rows.push_back(table_row(MODE_MOVE, WHITE_KING, 4, 2, 0, 0, F_CASTLE, '0, 0, '0));
      rows.push_back(table_row(MODE_MOVE, BLACK_KING, 60, 62, 0, 0, F_CASTLE, '0, 0, '0));
      rows.push_back(table_row(MODE_MOVE, WHITE_KING, 4, 12, 0, 0, F_CASTLE, '0, 0, '0));
      rows.push_back(table_row(MODE_MOVE, WHITE_PAWN, 52, 60, 0, WHITE_QUEEN, F_PROMO, '0,
                               0, '0));
      rows.push_back(table_row(MODE_MOVE, WHITE_PAWN, 52, 60, 0, WHITE_QUEEN, F_PROMO, '0,
                               0, '0));
      rows.push_back(table_row(MODE_MOVE, NO_PIECE_A, 63, 0, NO_PIECE_C, NO_PIECE_A,
                               F_EP | F_CAP | F_CASTLE | F_PROMO, '0, 0, '0));
      rows.push_back(table_row(MODE_CLEAR, 0, 0, 0, 0, 0, F_NONE, '0, 1, '0));

      foreach (rows[i])
         send_item(rows[i].mode, rows[i].req, rows[i].fixed, rows[i].hash);

      // Random run, mostly moves, with some moves repeated to undo them.
      last_move = '0;
      for (int i = 0; i < 700; i++) begin
         sender_calm = (i >= 200 && i < 400);
         if (i == 450)
            wait_drained();
         pick             = $urandom_range(99);
         r                = '0;
         r.moving_piece   = 4'($urandom_range(15));
         r.from_square    = 6'($urandom_range(63));
         r.to_square      = 6'($urandom_range(63));
         r.captured_piece = 4'($urandom_range(15));
         r.promoted_piece = 4'($urandom_range(15));
         r.is_en_passant  = ($urandom_range(99) < 20);
         r.is_capture     = ($urandom_range(99) < 35);
         r.is_castling    = ($urandom_range(99) < 25);
         r.is_promotion   = ($urandom_range(99) < 25);
         r.key_word       = {$urandom, $urandom};
         // Half of the castling moves are made by a king to a castling file.
         if (r.is_castling && $urandom_range(1)) begin
            r.moving_piece   = $urandom_range(1) ? WHITE_KING : BLACK_KING;
            r.to_square[2:0] = $urandom_range(1) ? QUEEN_SIDE_FILE : KING_SIDE_FILE;
         end
         if (pick < 45) begin
            m = MODE_MOVE;
            if ($urandom_range(99) < 15)
               r = last_move;
            last_move = r;
         end else if (pick < 65) begin
            m = MODE_TOGGLE;
         end else if (pick < 77) begin
            m = MODE_LOAD;
         end else if (pick < 87) begin
            m = MODE_SIDE;
         end else if (pick < 92) begin
            m = MODE_CLEAR;
         end else begin
            m = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
         end
         send_item(m, r, 1'b0, '0);
      end
      sender_calm = 1'b0;

      // Let every hash come back, then keep watching for stray responses.
      wait_drained();
      repeat (12) @(posedge clock);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // Hard stop well beyond the slowest correct run.
   initial begin : watchdog
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/zmh_pkg.sv
rtl/zobrist_move_hash_update_core.sv
bench/testbench.sv
